// ===== hw/rtl/itr_pkg.sv =====
// itr_pkg: shared types, constants and helpers for the integer to radix text unit
// no dependencies
package itr_pkg;

	localparam int RADIX_W = 6;
	localparam int CHAR_W = 8;
	// quotient bits resolved per divider cycle
	localparam int DIV_BITS = 4;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] DEC_BASE = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_A = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

	typedef struct packed {
		logic neg;
		logic [RADIX_W-1:0] radix;
	} hdr_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_SIGN,
		BK_READ,
		BK_LOAD
	} bk_state_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] r;
		if (d < DEC_BASE) begin
			r = CHAR_ZERO + CHAR_W'(d);
		end else begin
			r = CHAR_A + CHAR_W'(d - DEC_BASE);
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/itr_value_if.sv =====
// itr_value_if: input channel carrying one signed integer per transfer
// uses no package
interface itr_value_if #(parameter int VALUE_BITS = 32);
	logic valid;
	logic ready;
	logic signed [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

// ===== hw/rtl/itr_char_if.sv =====
// itr_char_if: output channel carrying one ascii character per transfer
// uses itr_pkg for the character width
interface itr_char_if;
	logic valid;
	logic ready;
	logic [itr_pkg::CHAR_W-1:0] char_code;
	logic last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// ===== hw/rtl/itr_cfg_if.sv =====
// itr_cfg_if: write channel for the radix register
// uses itr_pkg for the register width
interface itr_cfg_if;
	logic valid;
	logic ready;
	logic [itr_pkg::RADIX_W-1:0] radix;

	modport source (output valid, output radix, input ready);
	modport sink (input valid, input radix, output ready);
endinterface

// ===== hw/rtl/itr_ram.sv =====
// itr_ram: generic single write, single read ram with registered read data
// no dependencies
module itr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== hw/rtl/itr_front.sv =====
// itr_front: radix register, input acceptance and sign/magnitude classification
// depends on itr_pkg, itr_value_if, itr_cfg_if
module itr_front #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_BASE = 36
) (
	input  logic                   clk,
	input  logic                   arst_n,
	itr_value_if.sink              num,
	itr_cfg_if.sink                cfg,
	input  itr_pkg::q_stat_t       q_stat,
	output logic                   push,
	output itr_pkg::hdr_t          push_hdr,
	output logic [VALUE_BITS-1:0]  push_mag
);

	logic [itr_pkg::RADIX_W-1:0] radix_q;
	logic                        cfg_ok;
	logic [VALUE_BITS-1:0]       raw;

	assign cfg.ready = 1'b1;
	assign cfg_ok = (cfg.radix >= itr_pkg::RADIX_MIN) &&
			(cfg.radix <= itr_pkg::RADIX_W'(MAX_BASE));

	// out-of-range radix writes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= itr_pkg::RADIX_RESET;
		end else if (cfg.valid && cfg_ok) begin
			radix_q <= cfg.radix;
		end
	end

	assign num.ready = !q_stat.full;
	assign push = num.valid && !q_stat.full;

	// only decimal prints a sign, other radixes see the raw bit pattern
	assign raw = num.value;
	assign push_hdr.radix = radix_q;
	assign push_hdr.neg = (radix_q == itr_pkg::DEC_BASE) && raw[VALUE_BITS-1];
	assign push_mag = push_hdr.neg ? (~raw + VALUE_BITS'(1)) : raw;

endmodule

// ===== hw/rtl/itr_fifo.sv =====
// itr_fifo: two-entry queue between front and back
// depends on itr_pkg for the status struct
module itr_fifo #(
	parameter int WIDTH = 39
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output itr_pkg::q_stat_t stat
);

	logic [WIDTH-1:0] ent_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign do_push = push && !stat.full;
	assign do_pop = pop && !stat.empty;
	assign head = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/itr_back.sv =====
// itr_back: iterative radix divider, digit store and character output register
// depends on itr_pkg, itr_char_if, itr_ram
module itr_back #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  itr_pkg::q_stat_t      q_stat,
	input  itr_pkg::hdr_t         q_hdr,
	input  logic [VALUE_BITS-1:0] q_mag,
	output logic                  q_pop,
	itr_char_if.source            txt
);

	localparam int DB = itr_pkg::DIV_BITS;
	localparam int RW = itr_pkg::RADIX_W;
	localparam int PAD_BITS = ((VALUE_BITS + DB - 1) / DB) * DB;
	localparam int STEPS = PAD_BITS / DB;
	localparam int SW = $clog2(STEPS);
	localparam int DEPTH = VALUE_BITS;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	itr_pkg::bk_state_t st_q, st_d;

	logic [PAD_BITS-1:0] dv_q, dv_nxt;
	logic [RW-1:0]       rem_q, rem_nxt;
	logic [RW-1:0]       radix_q;
	logic                neg_q;
	logic [SW-1:0]       step_q;
	logic [CW-1:0]       cnt_q, cnt_m1;
	logic                ov_q;
	logic [itr_pkg::CHAR_W-1:0] och_q;
	logic                olast_q;

	logic [PAD_BITS-1:0] dv_v;
	logic [RW:0]         t_v;
	logic [RW-1:0]       r_v;

	logic          last_step;
	logic          quo_zero;
	logic          free;
	logic          wr_en;
	logic          ld_sign;
	logic          ld_dig;
	logic [AW-1:0] rd_addr;
	logic [RW-1:0] rd_digit;

	// restoring division, DB quotient bits per cycle
	always_comb begin
		dv_v = dv_q;
		r_v = rem_q;
		t_v = '0;
		for (int i = 0; i < DB; i++) begin
			t_v = {r_v, dv_v[PAD_BITS-1]};
			if (t_v >= {1'b0, radix_q}) begin
				r_v = RW'(t_v - {1'b0, radix_q});
				dv_v = {dv_v[PAD_BITS-2:0], 1'b1};
			end else begin
				r_v = t_v[RW-1:0];
				dv_v = {dv_v[PAD_BITS-2:0], 1'b0};
			end
		end
		dv_nxt = dv_v;
		rem_nxt = r_v;
	end

	assign last_step = (step_q == SW'(STEPS - 1));
	assign quo_zero = (dv_nxt == '0);
	assign free = !ov_q || txt.ready;
	assign cnt_m1 = cnt_q - CW'(1);
	assign rd_addr = (st_q == itr_pkg::BK_READ) ? cnt_m1[AW-1:0] : cnt_q[AW-1:0];

	itr_ram #(
		.WIDTH(RW),
		.DEPTH(DEPTH)
	) u_digits (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(cnt_q[AW-1:0]),
		.wr_data(rem_nxt),
		.rd_addr(rd_addr),
		.rd_data(rd_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= itr_pkg::BK_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		q_pop = 1'b0;
		wr_en = 1'b0;
		ld_sign = 1'b0;
		ld_dig = 1'b0;
		unique case (st_q)
			itr_pkg::BK_IDLE: begin
				if (!q_stat.empty) begin
					q_pop = 1'b1;
					st_d = itr_pkg::BK_DIV;
				end
			end
			itr_pkg::BK_DIV: begin
				if (last_step) begin
					wr_en = 1'b1;
					if (quo_zero) begin
						st_d = neg_q ? itr_pkg::BK_SIGN : itr_pkg::BK_READ;
					end
				end
			end
			itr_pkg::BK_SIGN: begin
				if (free) begin
					ld_sign = 1'b1;
					st_d = itr_pkg::BK_READ;
				end
			end
			itr_pkg::BK_READ: begin
				st_d = itr_pkg::BK_LOAD;
			end
			itr_pkg::BK_LOAD: begin
				if (free) begin
					ld_dig = 1'b1;
					st_d = (cnt_q == '0) ? itr_pkg::BK_IDLE : itr_pkg::BK_READ;
				end
			end
			default: begin
				st_d = itr_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			cnt_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (q_pop) begin
				step_q <= '0;
				cnt_q <= '0;
			end else if (st_q == itr_pkg::BK_DIV) begin
				step_q <= last_step ? '0 : step_q + SW'(1);
				if (last_step) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end else if (st_q == itr_pkg::BK_READ) begin
				cnt_q <= cnt_m1;
			end
			if (ld_sign || ld_dig) begin
				ov_q <= 1'b1;
			end else if (txt.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			dv_q <= PAD_BITS'(q_mag);
			rem_q <= '0;
			radix_q <= q_hdr.radix;
			neg_q <= q_hdr.neg;
		end else if (st_q == itr_pkg::BK_DIV) begin
			dv_q <= dv_nxt;
			// remainder restarts for each new digit
			rem_q <= last_step ? '0 : rem_nxt;
		end
		if (ld_sign) begin
			och_q <= itr_pkg::CHAR_MINUS;
			olast_q <= 1'b0;
		end else if (ld_dig) begin
			och_q <= itr_pkg::digit_char(rd_digit);
			olast_q <= (cnt_q == '0);
		end
	end

	assign txt.valid = ov_q;
	assign txt.char_code = och_q;
	assign txt.last_char = olast_q;

endmodule

// ===== hw/rtl/integer_to_radix_ascii_unit.sv =====
// integer_to_radix_ascii_unit: one number in, its text in the radix register out
// each digit takes a full pass of the shared divider over the magnitude, least significant
// digit first into the digit ram; the characters are then read back from the ram, most
// significant digit first, after the minus sign when there is one
// one number is converted at a time, while up to two more wait in the queue
// reset: radix register to 10, queue empty, divider idle, no character pending
module integer_to_radix_ascii_unit #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_BASE = 36
) (
	input  logic       clk,
	input  logic       arst_n,
	itr_value_if.sink  num,
	itr_cfg_if.sink    cfg,
	itr_char_if.source txt
);

	localparam int HW = $bits(itr_pkg::hdr_t);

	itr_pkg::q_stat_t      q_stat;
	logic                  q_push;
	logic                  q_pop;
	itr_pkg::hdr_t         push_hdr;
	logic [VALUE_BITS-1:0] push_mag;
	logic [HW+VALUE_BITS-1:0] q_head;
	itr_pkg::hdr_t         head_hdr;
	logic [VALUE_BITS-1:0] head_mag;

	itr_front #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_BASE  (MAX_BASE)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.num     (num),
		.cfg     (cfg),
		.q_stat  (q_stat),
		.push    (q_push),
		.push_hdr(push_hdr),
		.push_mag(push_mag)
	);

	itr_fifo #(
		.WIDTH(HW + VALUE_BITS)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data({push_hdr, push_mag}),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	assign head_hdr = q_head[HW+VALUE_BITS-1:VALUE_BITS];
	assign head_mag = q_head[VALUE_BITS-1:0];

	itr_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.q_stat(q_stat),
		.q_hdr (head_hdr),
		.q_mag (head_mag),
		.q_pop (q_pop),
		.txt   (txt)
	);

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> !q_stat.empty)
		else $error("queue empty after a push");

	a_radix_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (push_hdr.radix >= itr_pkg::RADIX_MIN &&
			push_hdr.radix <= itr_pkg::RADIX_W'(MAX_BASE)))
		else $error("radix out of range entered the queue");

	a_neg_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && push_hdr.neg |-> push_hdr.radix == itr_pkg::DEC_BASE)
		else $error("sign flagged outside decimal");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		txt.valid && txt.char_code == itr_pkg::CHAR_MINUS |-> !txt.last_char)
		else $error("minus sign marked as last character");

endmodule

// ===== sim/integer_to_radix_ascii_unit_test.sv =====
// integer_to_radix_ascii_unit_test: checks the radix text converter against a behavioral predictor
// drives numbers and radix writes, compares every character; needs itr_pkg, the three
// channel interfaces and integer_to_radix_ascii_unit
`timescale 1ns / 100ps

module integer_to_radix_ascii_unit_test;

	localparam int VALUE_BITS = 32;
	localparam int MAX_BASE = 36;
	localparam int TAIL_CYCLES = 400;
	localparam longint LIMIT_NS = 2_000_000;

	typedef struct packed {
		logic [itr_pkg::CHAR_W-1:0] code;
		logic last;
	} text_char_t;

	typedef enum int {
		RX_FREE,
		RX_CHOPPY,
		RX_SLOW
	} rx_mode_t;

	logic clk;
	logic arst_n;

	itr_value_if #(.VALUE_BITS(VALUE_BITS)) num_if ();
	itr_cfg_if cfg_if ();
	itr_char_if txt_if ();

	integer_to_radix_ascii_unit #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_BASE(MAX_BASE)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.num(num_if),
		.cfg(cfg_if),
		.txt(txt_if)
	);

	text_char_t expected_text[$];
	logic [itr_pkg::RADIX_W-1:0] radix_now;

	int fail_count;
	int numbers_sent;
	int chars_seen;
	int numbers_done;
	int radix_writes;
	int radix_rejects;

	// sender burst shaping
	bit tx_gappy;
	int burst_left;

	// receiver control, read by the ready process
	rx_mode_t rx_mode;
	int hold_len;
	int hold_asked;

	always #1 clk = ~clk;

	initial begin
		#(LIMIT_NS);
		$display("timeout after %0d ns", LIMIT_NS);
		$display("[integer_to_radix_ascii_unit] ERROR");
		$finish;
	end

	task automatic report_fail(input string msg);
		$display("%0t: %s", $time, msg);
		fail_count++;
	endtask

	// expected text of one number in the current radix
	function automatic void predict_text(input logic [VALUE_BITS-1:0] raw);
		logic [VALUE_BITS-1:0] mag;
		logic [VALUE_BITS-1:0] base;
		logic [VALUE_BITS-1:0] d;
		logic [itr_pkg::CHAR_W-1:0] digs[0:VALUE_BITS];
		logic neg;
		int nd;
		base = VALUE_BITS'(radix_now);
		neg = (radix_now == itr_pkg::DEC_BASE) && raw[VALUE_BITS-1];
		mag = neg ? (~raw + 1'b1) : raw;
		nd = 0;
		do begin
			d = mag % base;
			if (d < VALUE_BITS'(itr_pkg::DEC_BASE))
				digs[nd] = itr_pkg::CHAR_ZERO + itr_pkg::CHAR_W'(d);
			else
				digs[nd] = itr_pkg::CHAR_A +
					itr_pkg::CHAR_W'(d - VALUE_BITS'(itr_pkg::DEC_BASE));
			nd++;
			mag = mag / base;
		end while (mag != 0);
		if (neg)
			expected_text.push_back('{code: itr_pkg::CHAR_MINUS, last: 1'b0});
		for (int i = nd - 1; i >= 0; i--)
			expected_text.push_back('{code: digs[i], last: (i == 0)});
	endfunction

	task automatic send_number(input logic [VALUE_BITS-1:0] v);
		int gap;
		if (tx_gappy) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 10);
				burst_left = $urandom_range(1, 8);
				num_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left--;
		end
		num_if.valid <= 1'b1;
		num_if.value <= v;
		do
			@(posedge clk);
		while (!(num_if.valid && num_if.ready));
		predict_text(v);
		numbers_sent++;
	endtask

	// sender pauses until every expected character has come back
	task automatic drain_text();
		num_if.valid <= 1'b0;
		while (expected_text.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_radix(input logic [itr_pkg::RADIX_W-1:0] r);
		cfg_if.valid <= 1'b1;
		cfg_if.radix <= r;
		do
			@(posedge clk);
		while (!(cfg_if.valid && cfg_if.ready));
		radix_writes++;
		if (r >= itr_pkg::RADIX_MIN && r <= itr_pkg::RADIX_W'(MAX_BASE))
			radix_now = r;
		else
			radix_rejects++;
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [VALUE_BITS-1:0] pick_value();
		logic [VALUE_BITS-1:0] v;
		logic [63:0] p;
		int k;
		case ($urandom_range(0, 5))
			0, 1: v = $urandom;
			2: begin
				v = $urandom_range(0, 200);
				if ($urandom_range(0, 1))
					v = -v;
			end
			3: begin
				if ($urandom_range(0, 1))
					v = 32'h8000_0000 + $urandom_range(0, 3);
				else
					v = 32'h7fff_ffff - $urandom_range(0, 3);
			end
			4: begin
				// around a power of the radix, where the digit count changes
				p = 1;
				k = $urandom_range(1, 31);
				for (int i = 0; i < k && p * radix_now <= 64'hffff_ffff; i++)
					p = p * radix_now;
				v = p[VALUE_BITS-1:0] + VALUE_BITS'($urandom_range(0, 2)) - 1'b1;
			end
			default: begin
				v = 32'd1 << $urandom_range(0, 31);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	// receiver ready, with its own stall pattern and a long hold-off on request
	initial begin
		int hold_left;
		int stall_left;
		int hold_taken;
		hold_left = 0;
		stall_left = 0;
		hold_taken = 0;
		txt_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_taken != hold_asked) begin
				hold_taken = hold_asked;
				hold_left = hold_len;
			end
			if (hold_left > 0) begin
				hold_left--;
				txt_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				txt_if.ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_FREE: txt_if.ready <= 1'b1;
					RX_CHOPPY: begin
						if ($urandom_range(0, 3) == 0) begin
							stall_left = $urandom_range(0, 6);
							txt_if.ready <= 1'b0;
						end else begin
							txt_if.ready <= 1'b1;
						end
					end
					default: begin
						// mostly stalled, one transfer at a time
						stall_left = $urandom_range(1, 4);
						txt_if.ready <= 1'b1;
					end
				endcase
			end
		end
	end

	// character checker
	always @(posedge clk) begin
		if (arst_n && txt_if.valid && txt_if.ready) begin
			chars_seen++;
			if (txt_if.last_char)
				numbers_done++;
			if (expected_text.size() == 0) begin
				report_fail($sformatf("unexpected character %02h last %0b",
					txt_if.char_code, txt_if.last_char));
			end else begin
				if (txt_if.char_code !== expected_text[0].code)
					report_fail($sformatf("char_code got %02h want %02h",
						txt_if.char_code, expected_text[0].code));
				if (txt_if.last_char !== expected_text[0].last)
					report_fail($sformatf("last_char got %0b want %0b (char %02h)",
						txt_if.last_char, expected_text[0].last, expected_text[0].code));
				void'(expected_text.pop_front());
			end
		end
	end

	// radix 10 straight out of reset, no write yet
	task automatic test_reset_decimal();
		tx_gappy = 1'b0;
		rx_mode = RX_FREE;
		send_number(32'd0);
		send_number(32'd1);
		send_number(-32'sd1);
		send_number(-32'sd7);
		send_number(32'h7fff_ffff);
		send_number(32'h8000_0000);
		send_number(32'd1000000000);
		drain_text();
	endtask

	task automatic test_radix_extremes();
		rx_mode = RX_CHOPPY;
		write_radix(6'd2);
		send_number(32'd0);
		send_number(32'hffff_ffff);
		send_number(32'h8000_0000);
		send_number(32'h5555_5555);
		drain_text();
		write_radix(6'd36);
		send_number(32'd35);
		send_number(32'd36);
		send_number(32'hffff_ffff);
		send_number(32'h7fff_ffff);
		drain_text();
		// negative patterns convert unsigned outside radix 10
		write_radix(6'd16);
		send_number(32'hdead_beef);
		send_number(-32'sd1);
		drain_text();
		write_radix(6'd11);
		send_number(-32'sd10);
		drain_text();
		write_radix(6'd9);
		send_number(32'h8000_0000);
		drain_text();
	endtask

	// writes outside 2..36 leave the radix alone
	task automatic test_rejected_radix();
		write_radix(6'd8);
		write_radix(6'd0);
		write_radix(6'd1);
		write_radix(6'd37);
		write_radix(6'd63);
		send_number(32'd511);
		send_number(-32'sd8);
		drain_text();
	endtask

	task automatic test_random_phases();
		logic [itr_pkg::RADIX_W-1:0] r;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: r = 6'd2;
				1: r = 6'd36;
				2: r = 6'd10;
				3: r = 6'd16;
				6: r = 6'd10;
				default: r = itr_pkg::RADIX_W'($urandom_range(2, 36));
			endcase
			if ($urandom_range(0, 2) == 0)
				write_radix(itr_pkg::RADIX_W'($urandom_range(0, 1) ?
					$urandom_range(0, 1) : $urandom_range(37, 63)));
			write_radix(r);
			tx_gappy = (ph % 3) != 2;
			burst_left = 0;
			case (ph % 4)
				0: rx_mode = RX_CHOPPY;
				1: rx_mode = RX_SLOW;
				2: rx_mode = RX_FREE;
				default: rx_mode = RX_CHOPPY;
			endcase
			for (int i = 0; i < 16; i++)
				send_number(pick_value());
			drain_text();
		end
	endtask

	// receiver holds off while numbers keep coming, so the input stalls
	task automatic test_backpressure();
		write_radix(6'd2);
		tx_gappy = 1'b0;
		rx_mode = RX_FREE;
		hold_len = 600;
		hold_asked++;
		for (int i = 0; i < 8; i++)
			send_number($urandom);
		drain_text();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		num_if.valid = 1'b0;
		num_if.value = '0;
		cfg_if.valid = 1'b0;
		cfg_if.radix = itr_pkg::RADIX_RESET;
		radix_now = itr_pkg::RADIX_RESET;
		fail_count = 0;
		numbers_sent = 0;
		chars_seen = 0;
		numbers_done = 0;
		radix_writes = 0;
		radix_rejects = 0;
		tx_gappy = 1'b0;
		burst_left = 0;
		rx_mode = RX_FREE;
		hold_len = 0;
		hold_asked = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_decimal();
		test_radix_extremes();
		test_rejected_radix();
		test_random_phases();
		test_backpressure();

		num_if.valid <= 1'b0;
		rx_mode = RX_FREE;
		while (expected_text.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d numbers in radix 2 to 36, got %0d characters ending %0d numbers",
			numbers_sent, chars_seen, numbers_done);
		$display("%0d radix writes, %0d of them out of range; gaps, stalls and a long hold-off",
			radix_writes, radix_rejects);
		if (fail_count == 0) begin
			$display("[integer_to_radix_ascii_unit] OK");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("[integer_to_radix_ascii_unit] ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/itr_pkg.sv
hw/rtl/itr_value_if.sv
hw/rtl/itr_char_if.sv
hw/rtl/itr_cfg_if.sv
hw/rtl/itr_ram.sv
hw/rtl/itr_front.sv
hw/rtl/itr_fifo.sv
hw/rtl/itr_back.sv
hw/rtl/integer_to_radix_ascii_unit.sv
sim/integer_to_radix_ascii_unit_test.sv
